FILE: rtl/psjt_pkg.sv
// Package for the processor-sharing job tracker: sizes, word types and codes.
// Depends on nothing; used by the tracker and its checker.
`default_nettype none
package psjt_pkg;
    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 48;
    localparam int TAG_BITS  = 16;
    localparam int IDX_BITS  = $clog2(MAX_JOBS);
    localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);
    localparam logic [TIME_BITS-1:0] SERVICE_RESET = TIME_BITS'(65536);

    localparam logic OP_ARRIVAL   = 1'b0;
    localparam logic OP_DEPARTURE = 1'b1;
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_DROPPED   = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [TIME_BITS-1:0] now_time;
        logic [TAG_BITS-1:0]  job_tag;
    } t_in_word;

    typedef struct packed {
        logic                 departed_valid;
        logic [TAG_BITS-1:0]  departed_tag;
        logic                 next_valid;
        logic [TIME_BITS-1:0] next_departure;
        logic                 status;
    } t_out_word;
endpackage
`default_nettype wire

FILE: rtl/processor_sharing_job_tracker.sv
// Processor-sharing job tracker top level: job store, sequencer and separate
// subtract/shift/add datapaths. Depends on psjt_pkg.
//
// Usage: input words arrive on i_in_valid/o_in_stall and carry an opcode
// (arrival or departure), the current time and a job tag. Each accepted word
// produces exactly one output word on o_out_valid/i_out_stall.
// The tracker handles one word at a time. An arrival divides the elapsed time
// by the job count bit-serially, then passes once over the stored jobs (one
// entry a cycle) to reduce work and find the insertion point, then shifts
// entries (one a cycle), then multiplies the head work by the count with
// shift-and-add (one cycle a multiplier bit). A departure, or an arrival with
// no jobs or a full store, skips the division. The result waits in an output
// register; while it waits, or the receiver stalls, o_in_stall stays high, so
// a new word is taken at the earliest in the cycle after the output word
// leaves. Reset empties the store, clears the mark time and restores the
// service amount to 65536; job entries need no clearing. The user must write
// the service amount through i_cfg_we/i_cfg_data only while idle; the block
// itself does not enforce this.
`default_nettype none
module processor_sharing_job_tracker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  psjt_pkg::t_in_word          i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output psjt_pkg::t_out_word               o_out_data,
    input  wire                               i_cfg_we,
    input  wire  [psjt_pkg::TIME_BITS-1:0]    i_cfg_data
);
    localparam int TB = psjt_pkg::TIME_BITS;
    localparam int GB = psjt_pkg::TAG_BITS;
    localparam int IB = psjt_pkg::IDX_BITS;
    localparam int CB = psjt_pkg::CNT_BITS;
    localparam int NJ = psjt_pkg::MAX_JOBS;
    localparam logic [TB-1:0] TMAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_LOAD = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [TB-1:0]        r_service;
    logic [CB-1:0]        r_count;
    logic [TB-1:0]        r_mark;
    logic [TB-1:0]        r_work [NJ];
    logic [GB-1:0]        r_tag  [NJ];
    logic                 r_op;
    logic [TB-1:0]        r_now;
    logic [GB-1:0]        r_itag;
    logic [TB-1:0]        r_amt;
    logic [TB-1:0]        r_rem;
    logic [$clog2(TB+1)-1:0] r_bit;
    logic [CB-1:0]        r_i;
    logic [CB-1:0]        r_pos;
    logic                 r_found;
    logic [TB-1:0]        r_base;
    logic [TB:0]          r_acc;
    logic [TB+CB-1:0]     r_mcand;
    logic [CB-1:0]        r_mplier;
    logic                 r_ovf;
    logic                 r_out_valid;
    psjt_pkg::t_out_word  r_out;

    logic [TB:0]   w_trial;
    logic [TB-1:0] w_elapsed;
    logic [TB-1:0] w_sub;
    logic [IB-1:0] w_idx;
    logic [TB:0]   w_sum;

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_idx       = r_i[IB-1:0];
    assign w_elapsed   = (r_now > r_mark) ? r_now - r_mark : '0;
    assign w_trial     = {r_rem, r_amt[TB-1]} - {{(TB+1-CB){1'b0}}, r_count};
    assign w_sub       = (r_work[w_idx] > r_amt) ? r_work[w_idx] - r_amt : '0;
    assign w_sum       = r_acc + {1'b0, r_mcand[TB-1:0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid && !r_out_valid) n_state = S_DIV;
            S_DIV:  if (r_op == psjt_pkg::OP_DEPARTURE || r_count == '0 ||
                        r_count == CB'(NJ) || r_bit == '0) n_state = S_SCAN;
            S_SCAN: if (r_i >= r_count) n_state = S_MOVE;
            S_MOVE: if (r_i == r_pos) n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL:  if (r_mplier == '0) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_service   <= psjt_pkg::SERVICE_RESET;
            r_count     <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_service <= i_cfg_data;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !r_out_valid) begin
                        r_op   <= i_in_data.opcode;
                        r_now  <= i_in_data.now_time;
                        r_itag <= i_in_data.job_tag;
                        r_rem  <= '0;
                        r_bit  <= ($clog2(TB+1))'(TB);
                        r_amt  <= '0;
                        r_i    <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (r_op == psjt_pkg::OP_DEPARTURE) begin
                        r_amt  <= r_work[0];
                        r_itag <= r_tag[0];
                    end else if (r_count == '0 || r_count == CB'(NJ)) begin
                        r_amt <= '0;
                    end else if (r_bit == ($clog2(TB+1))'(TB)) begin
                        r_amt <= w_elapsed;
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        // Restoring division: quotient bits shift into r_amt.
                        if (!w_trial[TB]) begin
                            r_rem <= w_trial[TB-1:0];
                            r_amt <= {r_amt[TB-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[TB-2:0], r_amt[TB-1]};
                            r_amt <= {r_amt[TB-2:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                    end
                    if (n_state == S_SCAN) r_pos <= r_count;
                end
                S_SCAN: begin
                    if (r_i < r_count) begin
                        if (r_count != CB'(NJ) || r_op == psjt_pkg::OP_DEPARTURE) begin
                            r_work[w_idx] <= w_sub;
                            if (r_op == psjt_pkg::OP_ARRIVAL && !r_found &&
                                r_service < w_sub) begin
                                r_found <= 1'b1;
                                r_pos   <= r_i;
                            end
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i <= (r_op == psjt_pkg::OP_DEPARTURE) ? CB'(0) : r_count;
                        if (r_op == psjt_pkg::OP_DEPARTURE) r_pos <= r_count;
                    end
                end
                S_MOVE: begin
                    if (r_op == psjt_pkg::OP_ARRIVAL) begin
                        if (r_count != CB'(NJ)) begin
                            if (r_i == r_pos) begin
                                r_work[w_idx] <= r_service;
                                r_tag[w_idx]  <= r_itag;
                            end else begin
                                r_work[w_idx] <= r_work[IB'(r_i - 1'b1)];
                                r_tag[w_idx]  <= r_tag[IB'(r_i - 1'b1)];
                                r_i <= r_i - 1'b1;
                            end
                        end else begin
                            r_i <= r_pos;
                        end
                    end else if (r_i != r_pos) begin
                        if (r_i + 1'b1 < r_count) begin
                            r_work[w_idx] <= r_work[IB'(r_i + 1'b1)];
                            r_tag[w_idx]  <= r_tag[IB'(r_i + 1'b1)];
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_i <= r_pos;
                        end
                    end
                    if (n_state == S_LOAD) begin
                        r_out.departed_valid <= (r_op == psjt_pkg::OP_DEPARTURE) &&
                                                (r_count != '0);
                        r_out.departed_tag   <= ((r_op == psjt_pkg::OP_DEPARTURE) &&
                                                 (r_count != '0)) ? r_itag : '0;
                        r_out.status         <= ((r_op == psjt_pkg::OP_ARRIVAL) &&
                                                 (r_count == CB'(NJ))) ?
                                                psjt_pkg::ST_DROPPED : psjt_pkg::ST_OK;
                        if (r_op == psjt_pkg::OP_ARRIVAL) begin
                            if (r_count == CB'(NJ)) begin
                                r_base   <= r_mark;
                                r_mplier <= r_count;
                            end else begin
                                r_count  <= r_count + 1'b1;
                                r_mark   <= r_now;
                                r_base   <= r_now;
                                r_mplier <= r_count + 1'b1;
                            end
                        end else if (r_count != '0) begin
                            r_count  <= r_count - 1'b1;
                            r_mark   <= r_now;
                            r_base   <= r_now;
                            r_mplier <= r_count - 1'b1;
                        end else begin
                            r_base   <= '0;
                            r_mplier <= '0;
                        end
                    end
                end
                S_LOAD: begin
                    r_mcand <= {{CB{1'b0}}, r_work[0]};
                    r_acc   <= {1'b0, r_base};
                    r_ovf   <= 1'b0;
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        if (w_sum[TB] || r_mcand[TB+CB-1:TB] != '0) r_ovf <= 1'b1;
                        r_acc <= {1'b0, w_sum[TB-1:0]};
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end
                S_OUT: begin
                    r_out.next_valid     <= (r_count != '0);
                    r_out.next_departure <= (r_count == '0) ? '0 :
                                            (r_ovf ? TMAX : r_acc[TB-1:0]);
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/psjt_checker.sv
// Port-level checker for the processor-sharing job tracker, bound to the top.
// Depends on psjt_pkg.
`default_nettype none
module psjt_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       o_in_stall,
    input wire                       o_out_valid,
    input wire                       i_out_stall,
    input wire psjt_pkg::t_out_word  o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");
    a_drop_no_dep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == psjt_pkg::ST_DROPPED
        |-> !o_out_data.departed_valid && o_out_data.next_valid)
        else $error("dropped arrival reported a departure");
    a_idle_no_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.next_valid |-> o_out_data.next_departure == '0)
        else $error("departure time without jobs");
endmodule
bind processor_sharing_job_tracker psjt_checker u_psjt_checker (.*);
`default_nettype wire
